>>> sv/bgc_pkg.sv
// Shared types and constants for the button gesture classifier.
// No dependencies; compile first.
package bgc_pkg;

    localparam int TIME_W    = 32;
    localparam int THR_W     = 16;
    localparam int TICK_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [2:0] {
        OC_BOUNCE  = 3'd0,
        OC_PENDING = 3'd1,
        OC_STOPPED = 3'd2,
        OC_GESTURE = 3'd3,
        OC_UNDEF   = 3'd4,
        OC_QUIET   = 3'd5
    } t_outcome;

    typedef enum logic [1:0] {
        GS_NONE   = 2'd0,
        GS_SINGLE = 2'd1,
        GS_DOUBLE = 2'd2,
        GS_LONG   = 2'd3
    } t_gesture;

    localparam logic CMD_EDGE     = 1'b0;
    localparam logic CMD_TICK     = 1'b1;
    localparam logic LVL_RELEASED = 1'b0;
    localparam logic LVL_PRESSED  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE  = 3'd0,
        CFG_SHORT_MAX = 3'd1,
        CFG_LONG_MIN  = 3'd2,
        CFG_LONG_MAX  = 3'd3,
        CFG_CONFIRM   = 3'd4,
        CFG_SIMPLE    = 3'd5
    } t_cfg_idx;

    localparam logic [THR_W-1:0]  RST_DEBOUNCE  = 16'd100;
    localparam logic [THR_W-1:0]  RST_SHORT_MAX = 16'd1500;
    localparam logic [THR_W-1:0]  RST_LONG_MIN  = 16'd2001;
    localparam logic [THR_W-1:0]  RST_LONG_MAX  = 16'd8000;
    localparam logic [TICK_W-1:0] RST_CONFIRM   = 8'd15;

endpackage

>>> sv/bgc_if.sv
// Valid/ready channel interfaces for event beats in and result beats out.
// Depends on bgc_pkg.
interface bgc_in_if import bgc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic              pin_level;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, command, pin_level, now_ms, input ready);
    modport sink   (input valid, command, pin_level, now_ms, output ready);
endinterface

interface bgc_out_if import bgc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [2:0]        outcome;
    logic [1:0]        gesture;
    logic [TIME_W-1:0] hold_ms;

    modport source (output valid, outcome, gesture, hold_ms, input ready);
    modport sink   (input valid, outcome, gesture, hold_ms, output ready);
endinterface

>>> sv/button_gesture_classifier_top.sv
// Button gesture classifier: debounce, press timing, single/double/long press.
// A beat passes through the input register, then the result register, before it leaves as a result beat.
// Throughput: one beat per cycle; a held result stalls input only once both stages fill.
// Reset: synchronous active-low i_rst_n clears both stage valids, gesture state and
// timestamps, and loads the configuration registers with their defaults.
// Depends on bgc_pkg and bgc_if.
module button_gesture_classifier_top import bgc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    // channels
    bgc_in_if.sink               i_in,
    bgc_out_if.source            o_out
);

    // ---------------- configuration ----------------
    logic [THR_W-1:0]  r_debounce;
    logic [THR_W-1:0]  r_short_max;
    logic [THR_W-1:0]  r_long_min;
    logic [THR_W-1:0]  r_long_max;
    logic [TICK_W-1:0] r_confirm;
    logic              r_simple;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce  <= RST_DEBOUNCE;
            r_short_max <= RST_SHORT_MAX;
            r_long_min  <= RST_LONG_MIN;
            r_long_max  <= RST_LONG_MAX;
            r_confirm   <= RST_CONFIRM;
            r_simple    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE:  r_debounce  <= i_cfg_data;
                CFG_SHORT_MAX: r_short_max <= i_cfg_data;
                CFG_LONG_MIN:  r_long_min  <= i_cfg_data;
                CFG_LONG_MAX:  r_long_max  <= i_cfg_data;
                CFG_CONFIRM:   r_confirm   <= i_cfg_data[TICK_W-1:0];
                CFG_SIMPLE:    r_simple    <= i_cfg_data[0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // ---------------- stage 1: input register ----------------
    logic              r_in_vld;
    logic              r_cmd;
    logic              r_lvl;
    logic [TIME_W-1:0] r_now;
    logic              r_out_vld;
    logic              adv;       // stage 1 beat moves into the result register

    assign adv        = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_cmd <= i_in.command;
            r_lvl <= i_in.pin_level;
            r_now <= i_in.now_ms;
        end
    end

    // ---------------- gesture state ----------------
    logic [TIME_W-1:0] r_rise, n_rise;
    logic [TIME_W-1:0] r_fall, n_fall;
    logic              r_level, n_level;
    logic              r_await, n_await;
    logic              r_armed, n_armed;
    logic [TICK_W-1:0] r_left, n_left;

    logic [TIME_W-1:0] diff_r;
    logic [TIME_W-1:0] diff_f;
    logic [TIME_W-1:0] deb_ext;
    logic              is_bounce;
    logic              is_short;
    logic              is_long;
    logic              released;
    t_outcome          res_oc;
    t_gesture          res_gs;
    logic [TIME_W-1:0] res_hold;

    assign diff_r   = r_now - r_rise;
    assign diff_f   = r_now - r_fall;
    assign deb_ext  = {{(TIME_W-THR_W){1'b0}}, r_debounce};
    assign released = (r_lvl == LVL_RELEASED);

    // bounce: level unchanged, or too close to the last kept rise or fall
    assign is_bounce = (r_lvl == r_level) || (diff_r <= deb_ext) || (diff_f <= deb_ext);
    assign is_short  = diff_r <= {{(TIME_W-THR_W){1'b0}}, r_short_max};
    assign is_long   = ({{(TIME_W-THR_W){1'b0}}, r_long_min} <= diff_r) &&
                       (diff_r <= {{(TIME_W-THR_W){1'b0}}, r_long_max});

    always_comb begin
        n_rise   = r_rise;
        n_fall   = r_fall;
        n_level  = r_level;
        n_await  = r_await;
        n_armed  = r_armed;
        n_left   = r_left;
        res_oc   = OC_QUIET;
        res_gs   = GS_NONE;
        res_hold = '0;

        if (r_cmd == CMD_TICK) begin
            if (r_armed) begin
                if (r_left <= TICK_W'(1)) begin
                    // countdown ran out: confirm the pending single press
                    n_await = 1'b0;
                    n_armed = 1'b0;
                    n_left  = '0;
                    res_oc  = OC_GESTURE;
                    res_gs  = GS_SINGLE;
                end else begin
                    n_left = r_left - TICK_W'(1);
                end
            end
        end else begin
            res_hold = released ? diff_r : '0;
            n_level  = r_lvl;
            if (is_bounce) begin
                res_oc = OC_BOUNCE;
            end else begin
                if (released) n_fall = r_now;
                else          n_rise = r_now;

                if (r_simple) begin
                    // simple mode never touches the pending state
                    if (released && is_short) begin
                        res_oc = OC_GESTURE;
                        res_gs = GS_SINGLE;
                    end else if (released && is_long) begin
                        res_oc = OC_GESTURE;
                        res_gs = GS_LONG;
                    end else begin
                        res_oc = OC_UNDEF;
                    end
                end else if (released && !r_await && is_short) begin
                    n_await = 1'b1;
                    n_armed = 1'b1;
                    n_left  = r_confirm;
                    res_oc  = OC_PENDING;
                end else if (!released && r_await) begin
                    // second press: stop and clear the countdown, keep waiting
                    n_armed = 1'b0;
                    n_left  = '0;
                    res_oc  = OC_STOPPED;
                end else if (released && r_await && is_short) begin
                    n_await = 1'b0;
                    n_armed = 1'b0;
                    n_left  = '0;
                    res_oc  = OC_GESTURE;
                    res_gs  = GS_DOUBLE;
                end else if (released && !r_await && is_long) begin
                    res_oc = OC_GESTURE;
                    res_gs = GS_LONG;
                end else begin
                    n_await = 1'b0;
                    n_armed = 1'b0;
                    n_left  = '0;
                    res_oc  = OC_UNDEF;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise  <= '0;
            r_fall  <= '0;
            r_level <= LVL_RELEASED;
            r_await <= 1'b0;
            r_armed <= 1'b0;
            r_left  <= '0;
        end else if (adv) begin
            r_rise  <= n_rise;
            r_fall  <= n_fall;
            r_level <= n_level;
            r_await <= n_await;
            r_armed <= n_armed;
            r_left  <= n_left;
        end
    end

    // ---------------- stage 2: result register ----------------
    t_outcome          r_oc;
    t_gesture          r_gs;
    logic [TIME_W-1:0] r_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_oc   <= res_oc;
            r_gs   <= res_gs;
            r_hold <= res_hold;
        end
    end

    assign o_out.valid   = r_out_vld;
    assign o_out.outcome = r_oc;
    assign o_out.gesture = r_gs;
    assign o_out.hold_ms = r_hold;

endmodule

>>> sv/bgc_checker.sv
// Port-level checks for the button gesture classifier, bound to the top level.
// Depends on bgc_pkg and button_gesture_classifier_top.
module bgc_checker import bgc_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [2:0]        out_outcome,
    input logic [1:0]        out_gesture,
    input logic [TIME_W-1:0] out_hold_ms
);

    // a gesture code only rides on a gesture beat
    a_gesture_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && (out_gesture != GS_NONE) |-> (out_outcome == OC_GESTURE))
        else $error("gesture code on non-gesture beat");

    // quiet ticks carry no hold time
    a_quiet_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && (out_outcome == OC_QUIET) |-> (out_hold_ms == '0))
        else $error("hold time on quiet tick");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_outcome) &&
        $stable(out_gesture) && $stable(out_hold_ms))
        else $error("stalled result changed");

    // an empty result register always leaves the input side ready
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result beat after reset");

endmodule

bind button_gesture_classifier_top bgc_checker u_bgc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .in_ready    (i_in.ready),
    .out_valid   (o_out.valid),
    .out_ready   (o_out.ready),
    .out_outcome (o_out.outcome),
    .out_gesture (o_out.gesture),
    .out_hold_ms (o_out.hold_ms)
);
